>>> rtl/core/dsdn_pkg.sv
`timescale 1ns / 1ps

package dsdn_pkg;

  // Character codes seen by the field parser (six-bit codes).
  localparam logic [5:0] CH_TAB   = 6'd9;
  localparam logic [5:0] CH_CR    = 6'd13;
  localparam logic [5:0] CH_SPACE = 6'd32;
  localparam logic [5:0] CH_PLUS  = 6'd43;
  localparam logic [5:0] CH_MINUS = 6'd45;
  localparam logic [5:0] CH_ZERO  = 6'd48;
  localparam logic [5:0] CH_NINE  = 6'd57;

  localparam int YearBias  = 2000;
  localparam int EpochYear = 1996;
  localparam int YearDays  = 365;
  localparam int EpochN    = EpochYear + YearBias;
  // Days of biased years 0 .. EpochN-1.
  localparam int EpochDays = YearDays * EpochN + (EpochN - 1) / 4 - (EpochN - 1) / 100
                             + (EpochN - 1) / 400 + 1;

  // floor(q / 25) = (q * Div25Mul) >> Div25Shift, exact for q below 43690.
  localparam int Div25Shift = 20;
  localparam logic [15:0] Div25Mul = 16'((1 << Div25Shift) / 25 + 1);

  localparam int MonthCount = 12;
  localparam logic [8:0] MONTH_START [2][MonthCount] = '{
    '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181, 9'd212, 9'd243, 9'd273,
      9'd304, 9'd334},
    '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182, 9'd213, 9'd244, 9'd274,
      9'd305, 9'd335}
  };

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_DIGITS,
    PH_DONE
  } parse_phase_e;

  // Stage 1 -> stage 2.
  typedef struct packed {
    logic               valid;
    logic               bad;
    logic [3:0]         midx;
    logic signed [7:0]  day;
    logic [13:0]        n;
  } s1_t;

  // Stage 2 -> stage 3.
  typedef struct packed {
    logic               valid;
    logic               bad;
    logic [3:0]         midx;
    logic signed [7:0]  day;
    logic [13:0]        n;
    logic [11:0]        q;
    logic [6:0]         d25m;
    logic [11:0]        qn;
    logic [6:0]         d25n;
  } s2_t;

  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
    logic [8:0] r;
    r = 9'd0;
    if (idx < 4'(MonthCount)) begin
      r = MONTH_START[leap][idx];
    end
    return r;
  endfunction

  // atoi-like read of up to four characters; ch[0] is the first character.
  function automatic logic signed [14:0] parse_text(input logic [3:0][5:0] ch, input int len);
    parse_phase_e ph;
    logic         neg;
    logic [13:0]  v;
    logic [5:0]   c;
    logic         is_dig;
    ph  = PH_SKIP;
    neg = 1'b0;
    v   = 14'd0;
    for (int i = 0; i < 4; i++) begin
      c      = ch[i];
      is_dig = c inside {[CH_ZERO:CH_NINE]};
      if (i < len) begin
        case (ph)
          PH_SKIP: begin
            if (c inside {CH_SPACE, [CH_TAB:CH_CR]}) begin
              ph = PH_SKIP;
            end else if (c == CH_PLUS || c == CH_MINUS) begin
              neg = (c == CH_MINUS);
              ph  = PH_DIGITS;
            end else if (is_dig) begin
              v  = {10'd0, c[3:0]};
              ph = PH_DIGITS;
            end else begin
              ph = PH_DONE;
            end
          end
          PH_DIGITS: begin
            if (is_dig) begin
              v = 14'(v * 14'd10 + {10'd0, c[3:0]});
            end else begin
              ph = PH_DONE;
            end
          end
          default: ph = PH_DONE;
        endcase
      end
    end
    return neg ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

endpackage

>>> rtl/core/dsdn_parse.sv
`timescale 1ns / 1ps

module dsdn_parse (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [5:0]    month_tens_i,
  input  logic [5:0]    month_units_i,
  input  logic [5:0]    day_tens_i,
  input  logic [5:0]    day_units_i,
  input  logic [5:0]    year_thousands_i,
  input  logic [5:0]    year_hundreds_i,
  input  logic [5:0]    year_tens_i,
  input  logic [5:0]    year_units_i,
  output dsdn_pkg::s1_t s1_o
);

  logic signed [14:0] month, day, year;
  logic               bad_d, bad_q;
  logic [3:0]         midx_d, midx_q;
  logic signed [7:0]  day_d, day_q;
  logic [13:0]        n_d, n_q;
  logic               valid_q;

  always_comb begin
    month  = dsdn_pkg::parse_text({6'd0, 6'd0, month_units_i, month_tens_i}, 2);
    day    = dsdn_pkg::parse_text({6'd0, 6'd0, day_units_i, day_tens_i}, 2);
    year   = dsdn_pkg::parse_text({year_units_i, year_tens_i, year_hundreds_i,
                                   year_thousands_i}, 4);
    bad_d  = !(month inside {[15'sd1:15'sd12]});
    midx_d = bad_d ? 4'd0 : 4'(month - 15'sd1);
    day_d  = 8'(day);
    // Bias the year so it is always positive.
    n_d    = 14'(year + 15'(dsdn_pkg::YearBias));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    bad_q  <= bad_d;
    midx_q <= midx_d;
    day_q  <= day_d;
    n_q    <= n_d;
  end

  assign s1_o = '{valid: valid_q, bad: bad_q, midx: midx_q, day: day_q, n: n_q};

endmodule

>>> rtl/core/dsdn_div.sv
`timescale 1ns / 1ps

module dsdn_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dsdn_pkg::s1_t s1_i,
  output dsdn_pkg::s2_t s2_o
);

  logic [13:0] m;
  logic [11:0] q_d, qn_d;
  logic [27:0] pm, pn;
  logic        valid_q;
  logic        bad_q;
  logic [3:0]  midx_q;
  logic signed [7:0] day_q;
  logic [13:0] n_q;
  logic [11:0] q_q, qn_q;
  logic [6:0]  d25m_q, d25n_q;

  // Divide m = n-1 and n by 100 as (x/4)/25; one reciprocal multiply each.
  always_comb begin
    m    = s1_i.n - 14'd1;
    q_d  = m[13:2];
    qn_d = s1_i.n[13:2];
    pm   = 28'(q_d) * 28'(dsdn_pkg::Div25Mul);
    pn   = 28'(qn_d) * 28'(dsdn_pkg::Div25Mul);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= s1_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    bad_q  <= s1_i.bad;
    midx_q <= s1_i.midx;
    day_q  <= s1_i.day;
    n_q    <= s1_i.n;
    q_q    <= q_d;
    qn_q   <= qn_d;
    d25m_q <= pm[dsdn_pkg::Div25Shift +: 7];
    d25n_q <= pn[dsdn_pkg::Div25Shift +: 7];
  end

  assign s2_o = '{valid: valid_q, bad: bad_q, midx: midx_q, day: day_q, n: n_q,
                  q: q_q, d25m: d25m_q, qn: qn_q, d25n: d25n_q};

`ifndef SYNTHESIS
  a_valid_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q == $past(s1_i.valid))
    else $error("stage 2 valid does not follow stage 1");

  a_div25_exact : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ((13'(q_q) - 13'(d25m_q) * 13'd25) < 13'd25)
             && ((13'(qn_q) - 13'(d25n_q) * 13'd25) < 13'd25))
    else $error("reciprocal divide by 25 is off");
`endif

endmodule

>>> rtl/core/dsdn_accum.sv
`timescale 1ns / 1ps

module dsdn_accum (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dsdn_pkg::s2_t     s2_i,
  output logic              done_o,
  output logic signed [22:0] day_number_o,
  output logic              bad_month_o
);

  logic               leap;
  logic [22:0]        yp_d, yp_q;
  logic signed [9:0]  md_d, md_q;
  logic               v3_q, bad3_q;
  logic signed [23:0] sum;
  logic               done_q, bad_q;
  logic signed [22:0] day_q;

  // Stage 3: whole-year days, leap flag, month offset plus day.
  always_comb begin
    leap = (s2_i.n[1:0] == 2'd0)
        && ((s2_i.qn != 12'(s2_i.d25n) * 12'd25) || (s2_i.d25n[1:0] == 2'd0));
    yp_d = 23'(s2_i.n) * 23'(dsdn_pkg::YearDays) + 23'(s2_i.q) - 23'(s2_i.d25m)
         + 23'(s2_i.d25m[6:2]) + 23'd1;
    md_d = $signed({1'b0, dsdn_pkg::month_start(leap, s2_i.midx)}) + 10'(s2_i.day);
  end

  // Stage 4: subtract the epoch offset, force zero on a bad month.
  always_comb begin
    sum = $signed({1'b0, yp_q}) - 24'sd0 - 24'(dsdn_pkg::EpochDays) + 24'(md_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v3_q   <= s2_i.valid;
      done_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    yp_q   <= yp_d;
    md_q   <= md_d;
    bad3_q <= s2_i.bad;
    bad_q  <= bad3_q;
    day_q  <= bad3_q ? 23'sd0 : sum[22:0];
  end

  assign done_o       = done_q;
  assign day_number_o = day_q;
  assign bad_month_o  = bad_q;

`ifndef SYNTHESIS
  a_bad_is_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && bad_q) |-> (day_q == 23'sd0))
    else $error("bad month request gave a nonzero day number");

  a_done_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q == $past(s2_i.valid, 2))
    else $error("result strobe out of step with stage 2");
`endif

endmodule

>>> rtl/core/date_string_to_day_number_core.sv
`timescale 1ns / 1ps

// Pipeline: a request's result shows with done_o high for one cycle, after four
//   register stages: parse, divide, accumulate, output.
// Throughput: one request per cycle; busy stays low and the receiver cannot stall.
// Reset: rst_ni clears the stage valid bits at once; nothing else is held or swept.
module date_string_to_day_number_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [5:0]        month_tens_i,
  input  logic [5:0]        month_units_i,
  input  logic [5:0]        day_tens_i,
  input  logic [5:0]        day_units_i,
  input  logic [5:0]        year_thousands_i,
  input  logic [5:0]        year_hundreds_i,
  input  logic [5:0]        year_tens_i,
  input  logic [5:0]        year_units_i,
  output logic              done_o,
  output logic signed [22:0] day_number_o,
  output logic              bad_month_o
);

  dsdn_pkg::s1_t s1;
  dsdn_pkg::s2_t s2;

  // The pipeline never holds off a request: every stage advances each cycle.
  assign busy = 1'b0;

  // Stage 1: read month, day and year text; flag a bad month; bias the year.
  dsdn_parse u_parse (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (start && !busy),
    .month_tens_i     (month_tens_i),
    .month_units_i    (month_units_i),
    .day_tens_i       (day_tens_i),
    .day_units_i      (day_units_i),
    .year_thousands_i (year_thousands_i),
    .year_hundreds_i  (year_hundreds_i),
    .year_tens_i      (year_tens_i),
    .year_units_i     (year_units_i),
    .s1_o             (s1)
  );

  // Stage 2: four-year and century counts by reciprocal multiplies.
  dsdn_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .s1_i   (s1),
    .s2_o   (s2)
  );

  // Stages 3 and 4: add whole-year days, month offset and day; drop the epoch; zero a bad month.
  dsdn_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s2_i         (s2),
    .done_o       (done_o),
    .day_number_o (day_number_o),
    .bad_month_o  (bad_month_o)
  );

endmodule

>>> test/tb_date_string_to_day_number_core.sv
`timescale 1ns / 1ps

module tb_date_string_to_day_number_core;

  // Eight character codes of one date; index 0 is the month tens character,
  // index 7 the year units character (separators are not carried).
  typedef logic [7:0][5:0] date_text_t;

  typedef struct {
    logic [22:0] day_count;
    logic        bad_month;
  } day_result_t;

  localparam int CycleLimit = 100000;
  localparam int DrainCycles = 12;

  // Scoreboard: predict each accepted request and check the results in order.
  class day_count_board;
    day_result_t expected_days[$];
    int          mismatches;
    int          requests;
    int          results;
    int          bad_months;

    function new();
      mismatches = 0;
      requests   = 0;
      results    = 0;
      bad_months = 0;
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("[%0t] error: %s", $realtime, what);
    endtask

    function int pending();
      return expected_days.size();
    endfunction

    static function bit is_blank(logic [5:0] c);
      return c == dsdn_pkg::CH_SPACE
          || (c >= dsdn_pkg::CH_TAB && c <= dsdn_pkg::CH_CR);
    endfunction

    // Read a number the way atoi does: blanks, one sign, then digits.
    static function int read_number(date_text_t text, int first, int len);
      int k;
      int val;
      bit neg;
      k   = first;
      val = 0;
      neg = 1'b0;
      while (k < first + len && is_blank(text[k])) k++;
      if (k < first + len
          && (text[k] == dsdn_pkg::CH_PLUS || text[k] == dsdn_pkg::CH_MINUS)) begin
        neg = (text[k] == dsdn_pkg::CH_MINUS);
        k++;
      end
      while (k < first + len && text[k] >= dsdn_pkg::CH_ZERO
             && text[k] <= dsdn_pkg::CH_NINE) begin
        val = val * 10 + int'(text[k] - dsdn_pkg::CH_ZERO);
        k++;
      end
      return neg ? -val : val;
    endfunction

    // Days in years 0 .. n-1 of the shifted calendar (year 0 is leap), n >= 1.
    static function int shifted_year_days(int n);
      int m;
      m = n - 1;
      return 365 * n + m / 4 - m / 100 + m / 400 + 1;
    endfunction

    static function bit is_leap_year(int year);
      int b;
      b = year + 2000;
      if (b % 400 == 0) return 1'b1;
      if (b % 100 == 0) return 1'b0;
      return b % 4 == 0;
    endfunction

    static function int days_before_month(bit leap, int month);
      int offset;
      case (month)
        1:       offset = 0;
        2:       offset = 31;
        3:       offset = 59;
        4:       offset = 90;
        5:       offset = 120;
        6:       offset = 151;
        7:       offset = 181;
        8:       offset = 212;
        9:       offset = 243;
        10:      offset = 273;
        11:      offset = 304;
        default: offset = 334;
      endcase
      return (leap && month > 2) ? offset + 1 : offset;
    endfunction

    static function day_result_t date_to_day_count(date_text_t text);
      day_result_t r;
      int month;
      int day;
      int year;
      int count;
      month = read_number(text, 0, 2);
      day   = read_number(text, 2, 2);
      year  = read_number(text, 4, 4);
      if (month < 1 || month > 12) begin
        r.day_count = '0;
        r.bad_month = 1'b1;
      end else begin
        count = shifted_year_days(year + 2000) - shifted_year_days(1996 + 2000)
                + days_before_month(is_leap_year(year), month) + day;
        r.day_count = count[22:0];
        r.bad_month = 1'b0;
      end
      return r;
    endfunction

    function void note_request(date_text_t text);
      day_result_t r;
      r = date_to_day_count(text);
      requests++;
      if (r.bad_month) bad_months++;
      expected_days.push_back(r);
    endfunction

    task check_result(logic [22:0] day_count, logic bad_month);
      day_result_t want;
      results++;
      if (expected_days.size() == 0) begin
        report_mismatch($sformatf("result %0d/%0b with no request waiting",
                                  $signed(day_count), bad_month));
        return;
      end
      want = expected_days.pop_front();
      if (day_count !== want.day_count)
        report_mismatch($sformatf("result %0d: day_number %0d, want %0d", results,
                                  $signed(day_count), $signed(want.day_count)));
      if (bad_month !== want.bad_month)
        report_mismatch($sformatf("result %0d: bad_month %b, want %b", results,
                                  bad_month, want.bad_month));
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  date_text_t text_q;
  logic       done_o;
  logic signed [22:0] day_number_o;
  logic       bad_month_o;

  day_count_board board;
  int         cycles;

  date_string_to_day_number_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .month_tens_i     (text_q[0]),
    .month_units_i    (text_q[1]),
    .day_tens_i       (text_q[2]),
    .day_units_i      (text_q[3]),
    .year_thousands_i (text_q[4]),
    .year_hundreds_i  (text_q[5]),
    .year_tens_i      (text_q[6]),
    .year_units_i     (text_q[7]),
    .done_o           (done_o),
    .day_number_o     (day_number_o),
    .bad_month_o      (bad_month_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Check every strobed result at the edge that ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      board.check_result(day_number_o, bad_month_o);
    end
  end

  // Hard stop in case the block hangs or drops results.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("date_string_to_day_number_core: mismatch");
      $finish;
    end
  end

  // Take the low six bits of each of eight characters.
  function automatic date_text_t from_string(string s);
    date_text_t t;
    byte        b;
    for (int i = 0; i < 8; i++) begin
      b    = s[i];
      t[i] = b[5:0];
    end
    return t;
  endfunction

  function automatic logic [5:0] digit_char(int d);
    return dsdn_pkg::CH_ZERO + 6'(d);
  endfunction

  // Mostly digits, else blanks, signs or any code at all.
  function automatic logic [5:0] loose_char();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return digit_char($urandom_range(9));
    if (pick < 70) return dsdn_pkg::CH_SPACE;
    if (pick < 78) return 6'($urandom_range(dsdn_pkg::CH_TAB, dsdn_pkg::CH_CR));
    if (pick < 84) return dsdn_pkg::CH_PLUS;
    if (pick < 90) return dsdn_pkg::CH_MINUS;
    return 6'($urandom_range(63));
  endfunction

  function automatic date_text_t random_date();
    date_text_t t;
    int mode;
    int month;
    int day;
    int year;
    mode = $urandom_range(99);
    if (mode < 60) begin
      // Well-formed MMDDYYYY; years mostly near the epoch.
      month = $urandom_range(1, 12);
      day   = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(1, 31);
      year  = ($urandom_range(3) == 0) ? $urandom_range(9999) : $urandom_range(1880, 2120);
      t[0] = digit_char(month / 10);
      t[1] = digit_char(month % 10);
      t[2] = digit_char(day / 10);
      t[3] = digit_char(day % 10);
      t[4] = digit_char(year / 1000);
      t[5] = digit_char((year / 100) % 10);
      t[6] = digit_char((year / 10) % 10);
      t[7] = digit_char(year % 10);
    end else if (mode < 88) begin
      for (int i = 0; i < 8; i++) t[i] = loose_char();
    end else begin
      for (int i = 0; i < 8; i++) t[i] = 6'($urandom_range(63));
    end
    return t;
  endfunction

  // Present one request, hold it until accepted, then record it.
  // idle_pct is the chance of an idle cycle ahead of the request.
  task automatic send_date(date_text_t text, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start  <= 1'b1;
    text_q <= text;
    do @(posedge clk_i); while (busy);
    board.note_request(text);
  endtask

  // Drop start and hold off until every outstanding result is back.
  task automatic drain_results();
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    string      directed[$];
    date_text_t odd;
    int         idle_pct;

    board  = new();
    rst_ni = 1'b0;
    start  = 1'b0;
    text_q = '0;

    // Month tens, month units, day tens, day units, then the four year digits.
    directed = '{
      "01011996",    // the epoch day itself
      "12319999",    // last day of the largest year
      "01010000",    // year zero
      "02290000",    // leap day of year zero
      "03012000",    // century leap year
      "03011900",    // century that is not leap
      "03012400",
      "00151996",    // month zero
      "13011996",    // month just above range
      "99019999",
      "-1011996",    // negative month
      "+-010101",    // sign with no digits: month reads as zero
      " 1011996",    // leading blank in month
      "+2291996",    // plus sign before month
      "\t3-91996",   // tab before month, negative day
      "\0151001996", // carriage return before month
      "12999999",    // largest day field
      "0100-999",    // most negative year, day zero
      "05 1 123",    // blanks inside day and year
      "06+5+999",
      "07071-23",    // digits stop at the sign
      "0707    "     // blank year reads as zero
    };
    foreach (directed[i]) begin
      if (directed[i].len() != 8) $display("warning: directed entry %0d not 8 chars", i);
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_date(from_string(directed[i]), 0);
    // All-zero and all-one codes, and a good month with junk after it.
    send_date('0, 0);
    send_date('1, 0);
    odd       = '1;
    odd[0]    = dsdn_pkg::CH_ZERO;
    odd[1]    = digit_char(1);
    send_date(odd, 0);
    drain_results();

    // Random phases: back to back, sparse sender, then moderate idling.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       idle_pct = 0;
        1:       idle_pct = 62;
        default: idle_pct = 25;
      endcase
      for (int n = 0; n < 134; n++) begin
        send_date(random_date(), idle_pct);
        if ($urandom_range(59) == 0) drain_results();
      end
      drain_results();
    end

    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d dates (%0d with a bad month), %0d results checked",
             board.requests, board.bad_months, board.results);
    $display("directed edge cases plus random dates at 0, 62 and 25 percent sender idle");
    if (board.mismatches == 0) begin
      $display("date_string_to_day_number_core: match");
    end else begin
      $display("date_string_to_day_number_core: mismatch");
    end
    $finish;
  end

endmodule
